### rtl/asraf_pkg.sv
// Package: shared constants, register codes and control types for the spike-reject filter.
`default_nettype none
package asraf_pkg;

  localparam int unsigned WINDOW    = 4;
  localparam int unsigned SAMPLE_W  = 12;
  localparam int unsigned SLOT_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CNT_W     = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W     = SAMPLE_W + $clog2(WINDOW);
  localparam int unsigned RECIP_K   = SUM_W + CNT_W;
  localparam int unsigned RECIP_W   = RECIP_K + 1;
  localparam int unsigned PROD_W    = SUM_W + RECIP_W;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SPIKE_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_LOW     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_HIGH    = 2'd2;

  localparam logic [SAMPLE_W-1:0] MID_SCALE    = 12'd2048;
  localparam logic [SAMPLE_W-1:0] THRESH_RESET = 12'd500;
  localparam logic [SAMPLE_W-1:0] LOW_RESET    = 12'd100;
  localparam logic [SAMPLE_W-1:0] HIGH_RESET   = 12'd3995;

  typedef struct packed {
    logic accept;
    logic load_out;
  } cmd_t;

endpackage
`default_nettype wire

### rtl/asraf_sample_if.sv
// Interface: input sample channel with valid/ready handshake.
`default_nettype none
interface asraf_sample_if;
  logic                          valid;
  logic                          ready;
  logic [asraf_pkg::SAMPLE_W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface
`default_nettype wire

### rtl/asraf_result_if.sv
// Interface: filtered result channel with valid/ready handshake.
`default_nettype none
interface asraf_result_if;
  logic                          valid;
  logic                          ready;
  logic [asraf_pkg::SAMPLE_W-1:0] sample_out;
  logic                          was_replaced;

  modport source (output valid, output sample_out, output was_replaced, input ready);
  modport sink   (input valid, input sample_out, input was_replaced, output ready);
endinterface
`default_nettype wire

### rtl/asraf_ctrl.sv
// Controller: two-state sequencer for accept and result load, plus output valid.
`default_nettype none
module asraf_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output asraf_pkg::cmd_t     cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept, load_out;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign load_out   = (state_q == ST_DIV) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign cmd_o.accept   = accept;
  assign cmd_o.load_out = load_out;

endmodule
`default_nettype wire

### rtl/asraf_dp.sv
// Datapath: spike rejection, window store, running sum and reciprocal divide.
`default_nettype none
module asraf_dp (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire asraf_pkg::cmd_t                     cmd_i,
  input  wire logic [asraf_pkg::SAMPLE_W-1:0]      sample_in_i,
  input  wire logic                                cfg_we_i,
  input  wire logic [asraf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [asraf_pkg::SAMPLE_W-1:0]      cfg_data_i,
  output logic      [asraf_pkg::SAMPLE_W-1:0]      sample_out_o,
  output logic                                     was_replaced_o
);

  logic [asraf_pkg::SAMPLE_W-1:0] thresh_q, low_q, high_q;
  logic                           locked_q, locked_d;
  logic [asraf_pkg::SAMPLE_W-1:0] last_good_q, last_good_d;
  logic [asraf_pkg::SAMPLE_W-1:0] store_q [asraf_pkg::WINDOW];
  logic [asraf_pkg::SUM_W-1:0]    sum_q, sum_d;
  logic [asraf_pkg::SLOT_W-1:0]   slot_q, slot_d;
  logic [asraf_pkg::CNT_W-1:0]    fill_q, fill_d;
  logic                           repl_q, repl_d;
  logic [asraf_pkg::SAMPLE_W-1:0] clean;
  logic [asraf_pkg::SAMPLE_W-1:0] diff;
  logic [asraf_pkg::SAMPLE_W-1:0] quot_q;
  logic                           flag_q;
  logic [asraf_pkg::RECIP_W-1:0]  recip_tab [asraf_pkg::WINDOW + 1];
  logic [asraf_pkg::PROD_W-1:0]   prod;

  assign recip_tab[0] = '0;
  for (genvar g = 1; g <= asraf_pkg::WINDOW; g++) begin : g_recip
    localparam longint unsigned M = ((64'd1 << asraf_pkg::RECIP_K) + g - 1) / g;
    assign recip_tab[g] = asraf_pkg::RECIP_W'(M);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= asraf_pkg::THRESH_RESET;
      low_q    <= asraf_pkg::LOW_RESET;
      high_q   <= asraf_pkg::HIGH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        asraf_pkg::CFG_SPIKE_THRESHOLD: thresh_q <= cfg_data_i;
        asraf_pkg::CFG_STARTUP_LOW:     low_q    <= cfg_data_i;
        asraf_pkg::CFG_STARTUP_HIGH:    high_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign diff = (sample_in_i > last_good_q) ? (sample_in_i - last_good_q)
                                            : (last_good_q - sample_in_i);

  always_comb begin
    locked_d    = locked_q;
    last_good_d = last_good_q;
    clean       = sample_in_i;
    repl_d      = 1'b0;
    if (!locked_q) begin
      if ((sample_in_i > low_q) && (sample_in_i < high_q)) begin
        locked_d    = 1'b1;
        last_good_d = sample_in_i;
      end else begin
        clean  = last_good_q;
        repl_d = 1'b1;
      end
    end else if (diff > thresh_q) begin
      clean  = last_good_q;
      repl_d = 1'b1;
    end else begin
      last_good_d = sample_in_i;
    end
    sum_d  = sum_q - asraf_pkg::SUM_W'(store_q[slot_q]) + asraf_pkg::SUM_W'(clean);
    slot_d = (slot_q == asraf_pkg::SLOT_W'(asraf_pkg::WINDOW - 1)) ? '0 : slot_q + 1'b1;
    fill_d = (fill_q < asraf_pkg::CNT_W'(asraf_pkg::WINDOW)) ? fill_q + 1'b1 : fill_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      locked_q    <= 1'b0;
      last_good_q <= asraf_pkg::MID_SCALE;
      sum_q       <= '0;
      slot_q      <= '0;
      fill_q      <= '0;
      repl_q      <= 1'b0;
      for (int i = 0; i < asraf_pkg::WINDOW; i++) begin
        store_q[i] <= '0;
      end
    end else if (cmd_i.accept) begin
      locked_q        <= locked_d;
      last_good_q     <= last_good_d;
      sum_q           <= sum_d;
      slot_q          <= slot_d;
      fill_q          <= fill_d;
      repl_q          <= repl_d;
      store_q[slot_q] <= clean;
    end
  end

  assign prod = asraf_pkg::PROD_W'(sum_q) * asraf_pkg::PROD_W'(recip_tab[fill_q]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      quot_q <= prod[asraf_pkg::RECIP_K +: asraf_pkg::SAMPLE_W];
      flag_q <= repl_q;
    end
  end

  assign sample_out_o   = quot_q;
  assign was_replaced_o = flag_q;

endmodule
`default_nettype wire

### rtl/adc_spike_reject_average_filter_top.sv
// Top level: spike-rejecting moving-average filter for 12-bit ADC samples.
//
//   channel   direction  payload                     handshake
//   in_if     sink       sample_in[11:0]             valid/ready
//   out_if    source     sample_out[11:0], was_repl  valid/ready
//   cfg       write      cfg_we_i, cfg_idx_i[1:0],   none, one write per cycle
//                        cfg_data_i[11:0]
//
// For each sample, the accept cycle updates lock state, window and running
// sum; the divide state then divides by the fill count via a reciprocal
// multiply and loads the output register. A pending result holds while the
// sink stalls; one more sample is accepted meanwhile, then its divide state
// holds the input off until the sink takes the pending result. Reset clears
// the filter state and config registers at once; no clearing pass.
`default_nettype none
module adc_spike_reject_average_filter_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  asraf_sample_if.sink                         in_if,
  asraf_result_if.source                       out_if,
  input  wire logic                            cfg_we_i,
  input  wire logic [asraf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [asraf_pkg::SAMPLE_W-1:0]  cfg_data_i
);

  asraf_pkg::cmd_t cmd;

  asraf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .cmd_o       (cmd)
  );

  asraf_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sample_in_i    (in_if.sample_in),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .sample_out_o   (out_if.sample_out),
    .was_replaced_o (out_if.was_replaced)
  );

endmodule
`default_nettype wire

### tb/sv/adc_spike_reject_average_filter_top_tb.sv
// Testbench: streams ADC samples and register writes into the spike-reject filter, checks each result.
module adc_spike_reject_average_filter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import asraf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned N_SETUPS    = 12;
  localparam int unsigned SETUP_ITEMS = 150;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_out;
    logic                was_replaced;
  } avg_out_t;

  class spike_avg_tracker;
    int unsigned thr;
    int unsigned lo;
    int unsigned hi;
    bit          locked;
    int unsigned last_good;
    int unsigned win[WINDOW];
    int unsigned sum;
    int unsigned slot;
    int unsigned fill;
    avg_out_t    avg_due[$];
    int unsigned n_bad;
    int unsigned n_samples;
    int unsigned n_replaced;
    int unsigned n_writes;

    function new();
      thr       = THRESH_RESET;
      lo        = LOW_RESET;
      hi        = HIGH_RESET;
      locked    = 1'b0;
      last_good = MID_SCALE;
      foreach (win[i]) win[i] = 0;
      sum       = 0;
      slot      = 0;
      fill      = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] val);
      n_writes++;
      case (idx)
        CFG_SPIKE_THRESHOLD: thr = val;
        CFG_STARTUP_LOW:     lo  = val;
        CFG_STARTUP_HIGH:    hi  = val;
        default: ;
      endcase
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] raw);
      int unsigned s;
      int unsigned diff;
      avg_out_t    e;
      s = raw;
      e.was_replaced = 1'b0;
      if (!locked) begin
        if (s > lo && s < hi) begin
          last_good = s;
          locked    = 1'b1;
        end else begin
          s = last_good;
          e.was_replaced = 1'b1;
        end
      end else begin
        diff = (s > last_good) ? s - last_good : last_good - s;
        if (diff > thr) begin
          s = last_good;
          e.was_replaced = 1'b1;
        end else begin
          last_good = s;
        end
      end
      sum = sum - win[slot] + s;
      win[slot] = s;
      slot = (slot + 1) % WINDOW;
      if (fill < WINDOW) fill++;
      e.sample_out = SAMPLE_W'(sum / fill);
      avg_due.push_back(e);
      n_samples++;
      if (e.was_replaced) n_replaced++;
    endfunction

    function void check_output(logic [SAMPLE_W-1:0] avg, logic repl);
      avg_out_t e;
      if (avg_due.size() == 0) begin
        n_bad++;
        $display("%0t unexpected result: sample_out %0d was_replaced %0b", $time, avg, repl);
        return;
      end
      e = avg_due.pop_front();
      if (avg !== e.sample_out) begin
        n_bad++;
        $display("%0t sample_out mismatch: expected %0d actual %0d", $time, e.sample_out, avg);
      end
      if (repl !== e.was_replaced) begin
        n_bad++;
        $display("%0t was_replaced mismatch: expected %0b actual %0b", $time,
                 e.was_replaced, repl);
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [SAMPLE_W-1:0]  cfg_data_i;

  asraf_sample_if smp_if ();
  asraf_result_if res_if ();

  adc_spike_reject_average_filter_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (smp_if),
    .out_if     (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  spike_avg_tracker trk = new();

  int unsigned cycles = 0;
  int unsigned stall_left = 0;
  int unsigned ready_mode = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               trk.avg_due.size());
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      res_if.ready <= 1'b0;
    end else begin
      if ((cycles % 300) == 0) ready_mode = $urandom_range(0, 2);
      if ((ready_mode == 1 && $urandom_range(0, 3) == 0) ||
          (ready_mode == 2 && $urandom_range(0, 1) == 0)) begin
        stall_left = $urandom_range(0, 7);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      trk.check_output(res_if.sample_out, res_if.was_replaced);
    end
  end

  task automatic push_sample(input logic [SAMPLE_W-1:0] s);
    smp_if.valid     <= 1'b1;
    smp_if.sample_in <= s;
    @(posedge clk_i);
    while (!smp_if.ready) @(posedge clk_i);
    trk.note_sample(s);
  endtask

  task automatic hold_off(input int unsigned n);
    smp_if.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic settle();
    smp_if.valid <= 1'b0;
    while (trk.avg_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    trk.set_reg(idx, val);
  endtask

  task automatic close_writes();
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [SAMPLE_W-1:0] next_sample();
    int lg;
    int t;
    int v;
    int unsigned r;
    lg = trk.last_good;
    t  = trk.thr;
    r  = $urandom_range(0, 99);
    if (r < 65) begin
      v = lg + ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(0, t));
    end else if (r < 75) begin
      v = lg + ($urandom_range(0, 1) ? 1 : -1) * (t + int'($urandom_range(0, 1)));
    end else if (r < 88) begin
      if (lg + t + 1 <= 4095 && (lg - t - 1 < 0 || $urandom_range(0, 1)))
        v = $urandom_range(lg + t + 1, 4095);
      else if (lg - t - 1 >= 0)
        v = $urandom_range(0, lg - t - 1);
      else
        v = $urandom_range(0, 4095);
    end else begin
      v = $urandom_range(0, 4095);
    end
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return SAMPLE_W'(v);
  endfunction

  initial begin
    int unsigned burst;
    logic [SAMPLE_W-1:0] thr_val;
    rst_ni           = 1'b0;
    smp_if.valid     = 1'b0;
    smp_if.sample_in = '0;
    res_if.ready     = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = CFG_SPIKE_THRESHOLD;
    cfg_data_i       = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // unlocked, reset bounds: out of range and both bounds themselves
    push_sample(12'd0);
    push_sample(12'd4095);
    push_sample(LOW_RESET);
    push_sample(HIGH_RESET);

    // empty startup range: nothing can lock
    settle();
    write_reg(CFG_STARTUP_LOW, 12'd2000);
    write_reg(CFG_STARTUP_HIGH, 12'd2001);
    write_reg(CFG_UNUSED, 12'hfff);
    close_writes();
    push_sample(12'd2000);
    push_sample(12'd2001);
    push_sample(MID_SCALE);

    // widest range, zero threshold
    settle();
    write_reg(CFG_STARTUP_LOW, 12'd0);
    write_reg(CFG_STARTUP_HIGH, 12'd4095);
    write_reg(CFG_SPIKE_THRESHOLD, 12'd0);
    close_writes();
    push_sample(12'd0);
    push_sample(12'd4095);
    push_sample(12'd1);
    push_sample(12'd1);
    push_sample(12'd2);

    settle();
    write_reg(CFG_SPIKE_THRESHOLD, 12'd4095);
    close_writes();
    push_sample(12'd4095);
    push_sample(12'd0);

    settle();
    write_reg(CFG_SPIKE_THRESHOLD, THRESH_RESET);
    close_writes();
    push_sample(12'd500);
    push_sample(12'd1001);
    push_sample(12'd1000);

    for (int ph = 0; ph < N_SETUPS; ph++) begin
      settle();
      case (ph % 6)
        0:       thr_val = 12'd0;
        1:       thr_val = 12'd4095;
        2:       thr_val = SAMPLE_W'($urandom_range(1, 64));
        3:       thr_val = SAMPLE_W'($urandom_range(0, 4095));
        4:       thr_val = THRESH_RESET;
        default: thr_val = SAMPLE_W'($urandom_range(65, 600));
      endcase
      write_reg(CFG_SPIKE_THRESHOLD, thr_val);
      if (ph % 4 == 1) begin
        write_reg(CFG_STARTUP_LOW, 12'd4095);
        write_reg(CFG_STARTUP_HIGH, 12'd0);
      end else begin
        write_reg(CFG_STARTUP_LOW, SAMPLE_W'($urandom));
        write_reg(CFG_STARTUP_HIGH, SAMPLE_W'($urandom));
      end
      if ($urandom_range(0, 1)) write_reg(CFG_UNUSED, SAMPLE_W'($urandom));
      close_writes();
      burst = 0;
      for (int i = 0; i < SETUP_ITEMS; i++) begin
        if (burst == 0) begin
          burst = $urandom_range(1, 24);
          if (ph % 5 != 2 && $urandom_range(0, 2) != 0) hold_off($urandom_range(1, 6));
        end
        push_sample(next_sample());
        burst--;
      end
    end

    settle();
    repeat (10) @(posedge clk_i);
    $display("run covered %0d samples (%0d substituted) over %0d setups, %0d register writes",
             trk.n_samples, trk.n_replaced, N_SETUPS + 4, trk.n_writes);
    $display("%0d field mismatches, %0d results outstanding", trk.n_bad, trk.avg_due.size());
    if (trk.n_bad == 0 && trk.avg_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/asraf_pkg.sv
rtl/asraf_sample_if.sv
rtl/asraf_result_if.sv
rtl/asraf_ctrl.sv
rtl/asraf_dp.sv
rtl/adc_spike_reject_average_filter_top.sv
tb/sv/adc_spike_reject_average_filter_top_tb.sv
